// File: rtl/core/ppusa_pkg.sv
// Package for the scroll and address unit: item structs, command codes,
// fetch address constants. No dependencies.
`timescale 1ns / 1ps

package ppusa_pkg;

    // Command codes carried in the input item
    localparam logic [3:0] CMD_CTRL_WR   = 4'd0;
    localparam logic [3:0] CMD_MASK_WR   = 4'd1;
    localparam logic [3:0] CMD_STATUS_RD = 4'd2;
    localparam logic [3:0] CMD_SCROLL_WR = 4'd3;
    localparam logic [3:0] CMD_ADDR_WR   = 4'd4;
    localparam logic [3:0] CMD_DATA      = 4'd5;
    localparam logic [3:0] CMD_INC_X     = 4'd6;
    localparam logic [3:0] CMD_INC_Y     = 4'd7;
    localparam logic [3:0] CMD_COPY_X    = 4'd8;
    localparam logic [3:0] CMD_COPY_Y    = 4'd9;
    localparam logic [3:0] CMD_QUERY     = 4'd10;

    localparam logic [13:0] TILE_BASE     = 14'h2000;
    localparam logic [13:0] ATTR_BASE     = 14'h23C0;
    localparam logic [4:0]  COARSE_Y_LAST = 5'd29;
    localparam logic [4:0]  COARSE_X_LAST = 5'd31;
    localparam logic [2:0]  FINE_Y_LAST   = 3'd7;

    typedef struct packed {
        logic [3:0] command;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [14:0] vram_address;
        logic [2:0]  fine_x;
        logic        write_toggle;
        logic [13:0] tile_fetch_addr;
        logic [13:0] attr_fetch_addr;
        logic [2:0]  attr_shift;
    } out_item_t;

    // Scroll state as seen after one item's update
    typedef struct packed {
        logic [14:0] vram_address;
        logic [2:0]  fine_x;
        logic        write_toggle;
    } scroll_state_t;

endpackage

// File: rtl/core/ppusa_regs.sv
// Loopy register file: v, t, fine X, write toggle, increment mode, render enable.
// Depends on ppusa_pkg.
`timescale 1ns / 1ps

module ppusa_regs
    import ppusa_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  in_item_t      item,
    output scroll_state_t state_next
);

    logic [14:0] v_reg, v_next;
    logic [14:0] t_reg, t_next;
    logic [2:0]  fx_reg, fx_next;
    logic        toggle_reg, toggle_next;
    logic        row_step_reg, row_step_next;
    logic        render_reg, render_next;

    logic [14:0] v_inc_x, v_inc_y, t_lo;
    logic [7:0]  d;

    assign d = item.data;
    // t after the second address write; v takes the same value
    assign t_lo = {t_reg[14:8], d};

    always_comb begin
        if (v_reg[4:0] == COARSE_X_LAST) begin
            v_inc_x = {v_reg[14:11], ~v_reg[10], v_reg[9:5], 5'd0};
        end else begin
            v_inc_x = {v_reg[14:5], v_reg[4:0] + 5'd1};
        end
    end

    always_comb begin
        if (v_reg[14:12] != FINE_Y_LAST) begin
            v_inc_y = {v_reg[14:12] + 3'd1, v_reg[11:0]};
        end else if (v_reg[9:5] == COARSE_Y_LAST) begin
            v_inc_y = {3'd0, ~v_reg[11], v_reg[10], 5'd0, v_reg[4:0]};
        end else begin
            // row 31 wraps to 0 without a nametable flip
            v_inc_y = {3'd0, v_reg[11:10], v_reg[9:5] + 5'd1, v_reg[4:0]};
        end
    end

    always_comb begin
        v_next        = v_reg;
        t_next        = t_reg;
        fx_next       = fx_reg;
        toggle_next   = toggle_reg;
        row_step_next = row_step_reg;
        render_next   = render_reg;
        unique case (item.command)
            CMD_CTRL_WR: begin
                t_next        = {t_reg[14:12], d[1:0], t_reg[9:0]};
                row_step_next = d[2];
            end
            CMD_MASK_WR: begin
                render_next = |d[4:3];
            end
            CMD_STATUS_RD: begin
                toggle_next = 1'b0;
            end
            CMD_SCROLL_WR: begin
                if (!toggle_reg) begin
                    t_next  = {t_reg[14:5], d[7:3]};
                    fx_next = d[2:0];
                end else begin
                    t_next = {d[2:0], t_reg[11:10], d[7:3], t_reg[4:0]};
                end
                toggle_next = ~toggle_reg;
            end
            CMD_ADDR_WR: begin
                if (!toggle_reg) begin
                    t_next = {1'b0, d[5:0], t_reg[7:0]};
                end else begin
                    t_next = t_lo;
                    v_next = t_lo;
                end
                toggle_next = ~toggle_reg;
            end
            CMD_DATA: begin
                v_next = v_reg + (row_step_reg ? 15'd32 : 15'd1);
            end
            CMD_INC_X: begin
                if (render_reg) begin
                    v_next = v_inc_x;
                end
            end
            CMD_INC_Y: begin
                if (render_reg) begin
                    v_next = v_inc_y;
                end
            end
            CMD_COPY_X: begin
                if (render_reg) begin
                    v_next = {v_reg[14:11], t_reg[10], v_reg[9:5], t_reg[4:0]};
                end
            end
            CMD_COPY_Y: begin
                if (render_reg) begin
                    v_next = {t_reg[14:11], v_reg[10], t_reg[9:5], v_reg[4:0]};
                end
            end
            CMD_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg        <= '0;
            t_reg        <= '0;
            fx_reg       <= '0;
            toggle_reg   <= 1'b0;
            row_step_reg <= 1'b0;
            render_reg   <= 1'b0;
        end else if (step_en) begin
            v_reg        <= v_next;
            t_reg        <= t_next;
            fx_reg       <= fx_next;
            toggle_reg   <= toggle_next;
            row_step_reg <= row_step_next;
            render_reg   <= render_next;
        end
    end

    assign state_next.vram_address = v_next;
    assign state_next.fine_x       = fx_next;
    assign state_next.write_toggle = toggle_next;

endmodule

// File: rtl/core/ppusa_fetch.sv
// Fetch address decode: tile and attribute addresses and palette shift from v.
// Depends on ppusa_pkg.
`timescale 1ns / 1ps

module ppusa_fetch
    import ppusa_pkg::*;
(
    input  scroll_state_t state,
    output out_item_t     result
);

    logic [14:0] v;

    assign v = state.vram_address;

    assign result.vram_address    = v;
    assign result.fine_x          = state.fine_x;
    assign result.write_toggle    = state.write_toggle;
    assign result.tile_fetch_addr = TILE_BASE | {2'b00, v[11:0]};
    assign result.attr_fetch_addr = ATTR_BASE | {2'b00, v[11:10], 4'b0000, v[9:7], v[4:2]};
    // quadrant: coarse X bit 1 -> bit 0, coarse Y bit 1 -> bit 1, times two
    assign result.attr_shift      = {v[6], v[1], 1'b0};

endmodule

// File: rtl/core/ppu_scroll_address_registers.sv
// Top level of the scroll and address unit: input register, register file,
// fetch decode and result register. Depends on ppusa_pkg, ppusa_regs, ppusa_fetch.
//
//  channel | ports                     | payload
//  input   | s_valid, s_ready, s_data  | in_item_t  (command, data)
//  result  | m_valid, m_ready, m_data  | out_item_t (one per input item)
//
// One item per cycle sustained unless m_ready stalls it; m_data is registered.
// The update of v/t/fine X/toggle and the fetch decode sit between the input
// register and the result register, so the next item sees the new state.
// Synchronous active-low reset clears all scroll state and both valid flags.
// A stalled result holds; the input register still takes one item meanwhile.
`timescale 1ns / 1ps

module ppu_scroll_address_registers
    import ppusa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic          in_valid_reg, in_valid_next;
    in_item_t      in_item_reg;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_item_reg;
    logic          advance;
    scroll_state_t state_next;
    out_item_t     result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    ppusa_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .item       (in_item_reg),
        .state_next (state_next)
    );

    ppusa_fetch u_fetch (
        .state  (state_next),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

// File: rtl/core/ppusa_checker.sv
// Port-level checks for the scroll and address unit, bound to the top level.
// Depends on ppusa_pkg and ppu_scroll_address_registers.
`timescale 1ns / 1ps

module ppusa_checker
    import ppusa_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_tile: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.tile_fetch_addr[13:12] == 2'b10
                 && m_data.tile_fetch_addr[11:0] == m_data.vram_address[11:0])
        else $error("tile fetch address does not follow vram address");

    a_attr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.attr_fetch_addr[11:10] == m_data.vram_address[11:10]
                 && m_data.attr_fetch_addr[5:3] == m_data.vram_address[9:7]
                 && m_data.attr_fetch_addr[2:0] == m_data.vram_address[4:2]
                 && m_data.attr_shift[0] == 1'b0)
        else $error("attribute fetch fields do not follow vram address");

    // with no input at all, the input side stays ready once drained
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_valid && !m_valid |=> s_ready)
        else $error("input not ready with both stages empty");

endmodule

bind ppu_scroll_address_registers ppusa_checker u_ppusa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: verif/tb_ppu_scroll_address_registers.sv
// Testbench for ppu_scroll_address_registers: directed and random register accesses
// and render events, checked item by item against an in-bench scroll predictor.
// Depends on ppusa_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_ppu_scroll_address_registers;
    import ppusa_pkg::*;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd11;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    // predicted scroll state: v, t, fine X, toggle, increment mode, rendering
    logic [14:0] cur_v;
    logic [14:0] tmp_t;
    logic [2:0]  fine_x_q;
    logic        toggle_q;
    logic        row_step;
    logic        render_en;

    out_item_t pending_views[$];
    int        errors;
    bit        no_idle;
    bit        hold_request;

    ppu_scroll_address_registers uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Applies one command to the predicted state, returns the view after it
    function automatic out_item_t advance_scroll(input in_item_t it);
        logic [7:0] d;
        logic [4:0] cy;
        out_item_t  r;
        d = it.data;
        case (it.command)
            CMD_CTRL_WR: begin
                tmp_t[11:10] = d[1:0];
                row_step     = d[2];
            end
            CMD_MASK_WR: begin
                render_en = d[3] | d[4];
            end
            CMD_STATUS_RD: begin
                toggle_q = 1'b0;
            end
            CMD_SCROLL_WR: begin
                if (!toggle_q) begin
                    tmp_t[4:0] = d[7:3];
                    fine_x_q   = d[2:0];
                end else begin
                    tmp_t[9:5]   = d[7:3];
                    tmp_t[14:12] = d[2:0];
                end
                toggle_q = ~toggle_q;
            end
            CMD_ADDR_WR: begin
                if (!toggle_q) begin
                    tmp_t[14]   = 1'b0;
                    tmp_t[13:8] = d[5:0];
                end else begin
                    tmp_t[7:0] = d;
                    cur_v      = tmp_t;
                end
                toggle_q = ~toggle_q;
            end
            CMD_DATA: begin
                cur_v = cur_v + (row_step ? 15'd32 : 15'd1);
            end
            CMD_INC_X: begin
                if (render_en) begin
                    if (cur_v[4:0] == COARSE_X_LAST) begin
                        cur_v[4:0] = 5'd0;
                        cur_v[10]  = ~cur_v[10];
                    end else begin
                        cur_v[4:0] = cur_v[4:0] + 5'd1;
                    end
                end
            end
            CMD_INC_Y: begin
                if (render_en) begin
                    if (cur_v[14:12] != FINE_Y_LAST) begin
                        cur_v[14:12] = cur_v[14:12] + 3'd1;
                    end else begin
                        cur_v[14:12] = 3'd0;
                        cy = cur_v[9:5];
                        // row 29 is the last visible row; row 31 wraps to 0 without a flip
                        if (cy == COARSE_Y_LAST) begin
                            cy        = 5'd0;
                            cur_v[11] = ~cur_v[11];
                        end else begin
                            cy = cy + 5'd1;
                        end
                        cur_v[9:5] = cy;
                    end
                end
            end
            CMD_COPY_X: begin
                if (render_en) begin
                    cur_v[4:0] = tmp_t[4:0];
                    cur_v[10]  = tmp_t[10];
                end
            end
            CMD_COPY_Y: begin
                if (render_en) begin
                    cur_v[9:5]   = tmp_t[9:5];
                    cur_v[14:11] = tmp_t[14:11];
                end
            end
            default: ;
        endcase
        r.vram_address    = cur_v;
        r.fine_x          = fine_x_q;
        r.write_toggle    = toggle_q;
        r.tile_fetch_addr = TILE_BASE | {2'b00, cur_v[11:0]};
        r.attr_fetch_addr = ATTR_BASE | {2'b00, cur_v[11:10], 4'b0000, cur_v[9:7], cur_v[4:2]};
        r.attr_shift      = {cur_v[6], cur_v[1], 1'b0};
        return r;
    endfunction

    // Biased toward render events and paired writes so the state moves around
    function automatic in_item_t random_item();
        in_item_t it;
        int       r;
        r = $urandom_range(0, 99);
        it.data = 8'($urandom);
        if (r < 5)       it.command = CMD_CTRL_WR;
        else if (r < 12) it.command = CMD_MASK_WR;
        else if (r < 17) it.command = CMD_STATUS_RD;
        else if (r < 27) it.command = CMD_SCROLL_WR;
        else if (r < 37) it.command = CMD_ADDR_WR;
        else if (r < 47) it.command = CMD_DATA;
        else if (r < 60) it.command = CMD_INC_X;
        else if (r < 75) it.command = CMD_INC_Y;
        else if (r < 82) it.command = CMD_COPY_X;
        else if (r < 89) it.command = CMD_COPY_Y;
        else if (r < 94) it.command = CMD_QUERY;
        else             it.command = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [3:0] cmd, input logic [7:0] data);
        in_item_t it;
        it.command = cmd;
        it.data    = data;
        if (!no_idle && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_views.push_back(advance_scroll(it));
        @(negedge aclk);
    endtask

    task automatic compare_field(input string name, input logic [14:0] exp_v,
                                 input logic [14:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (pending_views.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual vram_address 0x%0h",
                         $time, m_data.vram_address);
            end else begin
                exp_item = pending_views.pop_front();
                compare_field("vram_address", exp_item.vram_address, m_data.vram_address);
                compare_field("fine_x", 15'(exp_item.fine_x), 15'(m_data.fine_x));
                compare_field("write_toggle", 15'(exp_item.write_toggle),
                              15'(m_data.write_toggle));
                compare_field("tile_fetch_addr", 15'(exp_item.tile_fetch_addr),
                              15'(m_data.tile_fetch_addr));
                compare_field("attr_fetch_addr", 15'(exp_item.attr_fetch_addr),
                              15'(m_data.attr_fetch_addr));
                compare_field("attr_shift", 15'(exp_item.attr_shift), 15'(m_data.attr_shift));
            end
        end
    end

    // Result side: random stalls, or one long hold-off when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // Queries, unused codes, and render events while rendering is off
    task automatic test_idle_commands();
        send_item(CMD_QUERY, 8'h00);
        send_item(CMD_UNUSED_HI, 8'hFF);
        send_item(CMD_MASK_WR, 8'h00);
        send_item(CMD_INC_X, 8'hFF);
        send_item(CMD_INC_Y, 8'hFF);
        send_item(CMD_COPY_X, 8'hFF);
        send_item(CMD_COPY_Y, 8'hFF);
    endtask

    // Control, address write cut off by a status read, address pair, data step, mask, scroll pair
    task automatic test_register_writes();
        send_item(CMD_CTRL_WR, 8'hFF);
        send_item(CMD_ADDR_WR, 8'hFF);
        send_item(CMD_STATUS_RD, 8'h00);
        send_item(CMD_ADDR_WR, 8'h7F);
        send_item(CMD_ADDR_WR, 8'hFF);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_MASK_WR, 8'h18);
        send_item(CMD_SCROLL_WR, 8'hFF);
        send_item(CMD_SCROLL_WR, 8'hFF);
    endtask

    // Copies, Y wrap at rows 31 and 29, coarse X wrap, data wrap past 0x7FFF
    task automatic test_render_events();
        send_item(CMD_COPY_Y, 8'h00);
        send_item(CMD_INC_Y, 8'h00);
        send_item(CMD_COPY_Y, 8'h00);
        send_item(CMD_COPY_X, 8'h00);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_INC_X, 8'h00);
        send_item(CMD_CTRL_WR, 8'h00);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_SCROLL_WR, 8'h00);
        send_item(CMD_SCROLL_WR, 8'hEF);
        send_item(CMD_COPY_Y, 8'h00);
        send_item(CMD_INC_Y, 8'h00);
    endtask

    task automatic test_random_traffic(input int count);
        in_item_t it;
        repeat (count) begin
            it = random_item();
            send_item(it.command, it.data);
        end
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure(input int count);
        hold_request = 1'b1;
        test_random_traffic(count);
    endtask

    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        test_random_traffic(count);
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        errors       = 0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        cur_v        = '0;
        tmp_t        = '0;
        fine_x_q     = '0;
        toggle_q     = 1'b0;
        row_step     = 1'b0;
        render_en    = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_idle_commands();
        test_register_writes();
        test_render_events();
        test_random_traffic(750);
        test_backpressure(100);
        test_back_to_back(300);

        s_valid <= 1'b0;
        wait (pending_views.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
